// ----- rtl/core/cdow_pkg.sv -----
// cdow_pkg: shared types, constants and small arithmetic helpers for the
// calendar weekday pipeline. No dependencies.
package cdow_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } request_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [2:0] first_weekday;
        logic [4:0] days_in_month;
        logic       leap_year;
        logic [2:0] grid_rows;
    } result_t;

    // Payload leaving the year split stages
    typedef struct packed {
        logic [4:0] day;
        logic [4:0] mm;            // month, Jan/Feb moved to 13/14
        logic [7:0] j;             // century of the shifted year, biased by +4 (400 years)
        logic [6:0] k;             // year within the century
        logic       leap;
        logic [4:0] days_in_month;
    } split_t;

    // Payload leaving the congruence stages
    typedef struct packed {
        logic [4:0] day;
        logic [2:0] base7;         // congruence without the day term, mod 7
        logic [4:0] days_in_month;
        logic       leap;
    } zel_t;

    // Month codes
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    localparam logic [4:0] DAYS_28 = 5'd28;
    localparam logic [4:0] DAYS_29 = 5'd29;
    localparam logic [4:0] DAYS_30 = 5'd30;
    localparam logic [4:0] DAYS_31 = 5'd31;

    localparam logic [2:0] ROWS_FIVE = 3'd5;
    localparam logic [2:0] ROWS_SIX  = 3'd6;
    localparam logic [5:0] GRID_CELLS = 6'd35;

    // floor(x/100) = (x*5243) >> 19, exact for x < 43690
    localparam int unsigned DIV100_RECIP = 5243;
    localparam int unsigned DIV100_SHIFT = 19;

    localparam logic [4:0] MONTH_SHIFT = 5'd12;
    localparam logic [7:0] CENTURY_BIAS = 8'd4;   // +400 years
    localparam logic [6:0] LAST_YEAR_OF_CENTURY = 7'd99;
    localparam logic [5:0] WEEKDAY_REENCODE = 6'd6;

    // floor(13*(mm+1)/5); x*205 >> 10 is exact for x < 1024
    function automatic logic [5:0] month_term(input logic [4:0] mm);
        logic [7:0]  x;
        logic [17:0] p;
        x = 8'd13 * (8'(mm) + 8'd1);
        p = 18'(x) * 18'd205;
        return 6'(p >> 10);
    endfunction

    // x mod 7; x*2341 >> 14 gives floor(x/7) for x < 5461
    function automatic logic [2:0] mod7(input logic [10:0] x);
        logic [22:0] p;
        logic [8:0]  q;
        logic [10:0] r;
        p = 23'(x) * 23'd2341;
        q = 9'(p >> 14);
        r = x - 11'(12'(q) * 12'd7);
        return r[2:0];
    endfunction

endpackage

// ----- rtl/core/cdow_split.sv -----
// cdow_split: two pipeline stages that split the year into century and
// year-of-century, shift Jan/Feb, and find leap flag and month length.
// Depends on cdow_pkg.
module cdow_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cdow_pkg::request_t  request,
    output logic                out_valid,
    input  logic                out_stall,
    output cdow_pkg::split_t    out_data
);

    // stage A: divide year by 100
    logic        a_valid_reg, a_valid_next;
    logic [4:0]  a_day_reg;
    logic [3:0]  a_month_reg;
    logic [13:0] a_year_reg;
    logic [7:0]  a_q100_reg, a_q100_next;
    logic [26:0] q100_prod;

    // stage B: century terms and month facts
    logic             b_valid_reg, b_valid_next;
    cdow_pkg::split_t b_data_reg, b_data_next;

    logic        b_move, a_move;
    logic [6:0]  r100;
    logic        jan_feb, borrow, leap;
    logic [4:0]  len;

    assign b_move   = !b_valid_reg || !out_stall;
    assign a_move   = !a_valid_reg || b_move;
    assign in_stall = !a_move;

    assign q100_prod   = 27'(request.year) * 27'(cdow_pkg::DIV100_RECIP);
    assign a_q100_next = 8'(q100_prod >> cdow_pkg::DIV100_SHIFT);
    assign a_valid_next = a_move ? in_valid : a_valid_reg;

    always_comb
    begin
        r100    = 7'(a_year_reg - 14'(16'(a_q100_reg) * 16'd100));
        jan_feb = (a_month_reg == cdow_pkg::MONTH_JAN) || (a_month_reg == cdow_pkg::MONTH_FEB);
        borrow  = jan_feb && (r100 == 7'd0);
        leap    = (a_year_reg[1:0] == 2'b00) && ((r100 != 7'd0) || (a_q100_reg[1:0] == 2'b00));

        unique case (a_month_reg) inside
            cdow_pkg::MONTH_FEB:
                len = leap ? cdow_pkg::DAYS_29 : cdow_pkg::DAYS_28;
            cdow_pkg::MONTH_APR, cdow_pkg::MONTH_JUN, cdow_pkg::MONTH_SEP, cdow_pkg::MONTH_NOV:
                len = cdow_pkg::DAYS_30;
            default:
                len = cdow_pkg::DAYS_31;
        endcase

        b_data_next.day  = a_day_reg;
        b_data_next.mm   = jan_feb ? 5'(a_month_reg) + cdow_pkg::MONTH_SHIFT : 5'(a_month_reg);
        // year + 400 - (Jan/Feb), split into century and remainder
        b_data_next.j    = a_q100_reg + cdow_pkg::CENTURY_BIAS - 8'(borrow);
        b_data_next.k    = borrow ? cdow_pkg::LAST_YEAR_OF_CENTURY : r100 - 7'(jan_feb);
        b_data_next.leap = leap;
        b_data_next.days_in_month = len;
    end

    assign b_valid_next = b_move ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            a_day_reg   <= request.day;
            a_month_reg <= request.month;
            a_year_reg  <= request.year;
            a_q100_reg  <= a_q100_next;
        end
        if (b_move)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ----- rtl/core/cdow_zeller.sv -----
// cdow_zeller: two pipeline stages that sum the congruence terms other than
// the day and reduce the sum mod 7. Depends on cdow_pkg.
module cdow_zeller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cdow_pkg::split_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cdow_pkg::zel_t    out_data
);

    // stage C: term sum
    logic        c_valid_reg, c_valid_next;
    logic [4:0]  c_day_reg;
    logic [4:0]  c_len_reg;
    logic        c_leap_reg;
    logic [10:0] c_sum_reg, c_sum_next;

    // stage D: mod 7
    logic           d_valid_reg, d_valid_next;
    cdow_pkg::zel_t d_data_reg, d_data_next;

    logic c_move, d_move;

    assign d_move   = !d_valid_reg || !out_stall;
    assign c_move   = !c_valid_reg || d_move;
    assign in_stall = !c_move;

    // floor(13(m+1)/5) + K + K/4 + J/4 + 5J, at most 1040
    assign c_sum_next = 11'(cdow_pkg::month_term(in_data.mm))
                      + 11'(in_data.k)
                      + 11'(in_data.k >> 2)
                      + 11'(in_data.j >> 2)
                      + 11'(in_data.j) * 11'd5;

    assign c_valid_next = c_move ? in_valid : c_valid_reg;
    assign d_valid_next = d_move ? c_valid_reg : d_valid_reg;

    always_comb
    begin
        d_data_next.day           = c_day_reg;
        d_data_next.base7         = cdow_pkg::mod7(c_sum_reg);
        d_data_next.days_in_month = c_len_reg;
        d_data_next.leap          = c_leap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_move)
        begin
            c_day_reg  <= in_data.day;
            c_len_reg  <= in_data.days_in_month;
            c_leap_reg <= in_data.leap;
            c_sum_reg  <= c_sum_next;
        end
        if (d_move)
        begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

// ----- rtl/core/calendar_day_of_week.sv -----
// calendar_day_of_week: top level of the Gregorian weekday pipeline.
// Depends on cdow_pkg, cdow_split and cdow_zeller.

// Takes one date request (day, month, year) per cycle unless stalled and
// returns the date's weekday and the weekday of the month's first day
// (0 Sunday .. 6 Saturday), the leap flag, the month length and the number
// of week rows of the month grid. The work is a five-stage pipeline: year
// divided by 100, century and month terms, congruence sum, mod 7 reduction,
// and the output register that adds the day. A request is taken every cycle
// while request_stall is low. The accepting edge loads the first of the five
// stage registers, and the result moves through the later ones in order to
// the output register that drives result_valid. Each stage holds its own valid
// bit and advances whenever the stage after it is empty or moving, so bubbles
// close up under result_stall and nothing is dropped or repeated. Inputs are
// not range checked: month 0 or 13..15 goes into the congruence raw with a
// 31-day length, and any day value is used as given.
module calendar_day_of_week (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  cdow_pkg::request_t  request,
    output logic                result_valid,
    input  logic                result_stall,
    output cdow_pkg::result_t   result
);

    logic             split_valid, split_stall;
    cdow_pkg::split_t split_data;
    logic             zel_valid, zel_stall;
    cdow_pkg::zel_t   zel_data;

    logic              result_valid_reg, result_valid_next;
    cdow_pkg::result_t result_reg, result_next;
    logic              out_move;
    logic [5:0]        day_sum;
    logic [5:0]        grid_fill;

    // stages 1-2
    cdow_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request_valid),
        .in_stall  (request_stall),
        .request   (request),
        .out_valid (split_valid),
        .out_stall (split_stall),
        .out_data  (split_data)
    );

    // stages 3-4
    cdow_zeller u_zeller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_stall  (split_stall),
        .in_data   (split_data),
        .out_valid (zel_valid),
        .out_stall (zel_stall),
        .out_data  (zel_data)
    );

    // stage 5: output register
    assign out_move  = !result_valid_reg || !result_stall;
    assign zel_stall = !out_move;
    assign result_valid_next = out_move ? zel_valid : result_valid_reg;

    always_comb
    begin
        // +6 re-encodes Zeller's Saturday-first count to Sunday-first
        day_sum   = 6'(zel_data.day) + 6'(zel_data.base7) + cdow_pkg::WEEKDAY_REENCODE;
        // day 1 plus the re-encode offset is 7, so the first weekday is base7
        grid_fill = 6'(zel_data.base7) + 6'(zel_data.days_in_month);

        result_next.weekday       = cdow_pkg::mod7(11'(day_sum));
        result_next.first_weekday = zel_data.base7;
        result_next.days_in_month = zel_data.days_in_month;
        result_next.leap_year     = zel_data.leap;
        result_next.grid_rows     = (grid_fill > cdow_pkg::GRID_CELLS) ?
                                    cdow_pkg::ROWS_SIX : cdow_pkg::ROWS_FIVE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // Back pressure reaches the request side only when the output is blocked.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> (result_valid && result_stall))
        else $error("request stalled while output is free");

    // Both weekdays stay in 0..6.
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.weekday != 3'd7) && (result.first_weekday != 3'd7)))
        else $error("weekday out of range");

    // A 29-day month only in a leap year, and 29 days only for a leap year.
    a_leap_length: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.days_in_month == cdow_pkg::DAYS_29)) |-> result.leap_year)
        else $error("29-day month outside a leap year");
`endif

endmodule
